// ===== src/kbd_dec_pkg.sv =====
package kbd_dec_pkg;

	// Result kinds carried on the result channel.
	localparam logic [1:0] KIND_NONE   = 2'd0;
	localparam logic [1:0] KIND_CHAR   = 2'd1;
	localparam logic [1:0] KIND_TERM   = 2'd2;
	localparam logic [1:0] KIND_STATUS = 2'd3;

	// Modifier flag positions.
	localparam int MOD_CTRL  = 0;
	localparam int MOD_ALT   = 1;
	localparam int MOD_SHIFT = 2;
	localparam int MOD_SUPER = 3;

	// Key codes with a meaning of their own.
	localparam logic [6:0] KEY_STATUS  = 7'h40;
	localparam logic [6:0] KEY_CAPS    = 7'h1A;
	localparam logic [6:0] KEY_F1      = 7'h61;
	localparam logic [6:0] KEY_F12     = 7'h6C;
	localparam logic [6:0] KEY_CASE    = 7'h20;
	localparam logic [3:0] LAST_TERM   = 4'd11;

	localparam logic [6:0] DIGIT_SHIFTED [10] = '{
		7'h29, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A, 7'h28
	};

	// Shifted form of a punctuation key.
	function automatic logic [6:0] shifted_punct(input logic [6:0] code);
		logic [6:0] r;
		unique case (code)
			7'h60: r = 7'h7E; // ` to ~
			7'h2C: r = 7'h3C; // , to <
			7'h2E: r = 7'h3E; // . to >
			7'h2F: r = 7'h3F; // / to ?
			7'h3B: r = 7'h3A; // ; to :
			7'h27: r = 7'h22; // ' to "
			7'h5B: r = 7'h7B; // [ to {
			7'h5D: r = 7'h7D; // ] to }
			7'h5C: r = 7'h7C; // \ to |
			7'h2D: r = 7'h5F; // - to _
			7'h3D: r = 7'h2B; // = to +
			default: r = 7'h00;
		endcase
		return r;
	endfunction

	// Character for a pressed key with no blocking modifier held; zero if none.
	function automatic logic [6:0] translate_key(input logic [6:0] code, input logic shift,
			input logic caps);
		logic [6:0] r;
		unique case (code) inside
			7'h20, [7'h08:7'h0D], 7'h1B, 7'h7F: r = code;
			[7'h41:7'h5A]: r = code | ((shift == caps) ? KEY_CASE : 7'h00);
			[7'h30:7'h39]: r = shift ? DIGIT_SHIFTED[code[3:0]] : code;
			7'h60, 7'h2C, 7'h2E, 7'h2F, 7'h3B, 7'h27, 7'h5B, 7'h5D, 7'h5C, 7'h2D, 7'h3D:
				r = shift ? shifted_punct(code) : code;
			default: r = 7'h00;
		endcase
		return r;
	endfunction

endpackage

// ===== src/keyboard_key_to_char_decoder.sv =====
// Channel   Direction  Handshake              Beat contents
// event     in         in_valid / in_ready    event_byte
// result    out        out_valid / out_ready  result_kind, char_code, terminal_index
//
// One beat in gives exactly one beat out, via the event and then the result register.
// A new event beat is taken every cycle unless the result stalls: the event
// register empties into the result register in the same cycle that it fills.
// The modifier, caps-lock and terminal state is updated as an event moves into
// the result register, so the next event always sees it.
// arst_n clears the state and both valid flags; payload registers are not reset.
// A stalled result holds its beat; the event register then fills and in_ready drops.
module keyboard_key_to_char_decoder
	import kbd_dec_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] event_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] result_kind,
	output logic [6:0] char_code,
	output logic [3:0] terminal_index
);

	// Event register stage.
	logic       valid_s1;
	logic [7:0] byte_s1;

	// Result register stage.
	logic       valid_s2;
	logic [1:0] kind_s2;
	logic [6:0] char_s2;

	// Decoder state.
	logic [3:0] mods_q;
	logic       caps_q;
	logic [3:0] term_q;

	logic       adv_s2;
	logic       adv_s1;

	// The result register can be loaded when it is empty or being emptied.
	assign adv_s2   = !valid_s2 || out_ready;
	assign adv_s1   = valid_s1 && adv_s2;
	assign in_ready = !valid_s1 || adv_s2;

	// Decode of the event held in the event register.
	logic [6:0] code;
	logic       pressed;
	logic       is_mod;
	logic [1:0] mod_idx;
	logic       is_fkey;
	logic [6:0] term_diff;
	logic [6:0] ch;
	logic [1:0] kind_d;
	logic [6:0] char_d;
	logic [3:0] mods_d;
	logic       caps_d;
	logic [3:0] term_d;

	assign code      = byte_s1[6:0];
	assign pressed   = !byte_s1[7];
	assign is_mod    = (code >= 7'h21 && code <= 7'h24) || (code >= 7'h71 && code <= 7'h74);
	// The low nibble of a modifier code counts from one; the flag index from zero.
	assign mod_idx   = code[1:0] - 2'd1;
	assign is_fkey   = code >= KEY_F1 && code <= KEY_F12;
	assign term_diff = code - KEY_F1;
	assign ch        = translate_key(code, mods_q[MOD_SHIFT], caps_q);

	always_comb begin
		kind_d = KIND_NONE;
		char_d = 7'h00;
		mods_d = mods_q;
		caps_d = caps_q;
		term_d = term_q;
		if (code == KEY_STATUS) begin
			// The status key ticks on press and on release alike.
			kind_d = KIND_STATUS;
		end else if (is_mod) begin
			// Left and right keys share a flag; press sets it, release clears it.
			mods_d[mod_idx] = pressed;
		end else if (code == KEY_CAPS && pressed) begin
			caps_d = !caps_q;
		end else if (pressed) begin
			if (mods_q[MOD_SUPER] && is_fkey) begin
				term_d = term_diff[3:0];
				kind_d = KIND_TERM;
			end else if (!mods_q[MOD_CTRL] && !mods_q[MOD_ALT] && !mods_q[MOD_SUPER]
					&& ch != 7'h00) begin
				// Ctrl, alt or super held swallows the character.
				kind_d = KIND_CHAR;
				char_d = ch;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			mods_q   <= 4'h0;
			caps_q   <= 1'b0;
			term_q   <= 4'h0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
			if (adv_s1) begin
				mods_q <= mods_d;
				caps_q <= caps_d;
				term_q <= term_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= event_byte;
		end
		if (adv_s1) begin
			kind_s2 <= kind_d;
			char_s2 <= char_d;
		end
	end

	assign out_valid      = valid_s2;
	assign result_kind    = kind_s2;
	assign char_code      = char_s2;
	// The terminal register is loaded together with the result register.
	assign terminal_index = term_q;

	// A character beat always carries a non-zero character, and no other kind does.
	a_char_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_CHAR |-> char_code != 7'h00)
		else $error("character beat without a character");

	a_char_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind != KIND_CHAR |-> char_code == 7'h00)
		else $error("character code on a non-character beat");

	a_term_range: assert property (@(posedge clk) disable iff (!arst_n)
		term_q <= LAST_TERM)
		else $error("terminal index out of range");

	// The active terminal moves only with a terminal-switch beat being presented.
	a_term_change: assert property (@(posedge clk) disable iff (!arst_n)
		term_q != $past(term_q) |-> valid_s2 && kind_s2 == KIND_TERM)
		else $error("terminal changed without a terminal switch");

endmodule
